/* rtl/core/assert_macros.svh */
// Assertion macros for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/tksel_pkg.sv */
package tksel_pkg;

  localparam int SCORE_W         = 32;
  localparam int CLASS_ID_W      = 10;
  localparam int RANK_W          = 4;
  localparam int TOPK_W          = 5;
  localparam int TOPK_MAX_DEF    = 16;
  localparam int MAX_CLASSES_DEF = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(5);

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [CLASS_ID_W-1:0]     class_id_t;

  typedef struct packed {
    score_t    score;
    class_id_t id;
    logic      keep;
    logic      last;
  } item_t;

  typedef struct packed {
    score_t    score;
    class_id_t id;
  } cell_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/tksel_front.sv */
module tksel_front #(
  parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tksel_pkg::score_t        in_score,
  input  logic                     in_last_score,
  input  logic                     q_full,
  output logic                     q_push,
  output tksel_pkg::item_t         q_item
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLASSES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = cnt_r < CNT_W'(MAX_CLASSES);

  assign q_item.score = in_score;
  assign q_item.id    = CLASS_ID_W'(cnt_r);
  assign q_item.keep  = keep;
  assign q_item.last  = in_last_score;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_last_score) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/tksel_queue.sv */
module tksel_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tksel_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output tksel_pkg::item_t  head
);
  import tksel_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign valid   = cnt_r != '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/tksel_back.sv */
module tksel_back #(
  parameter int TOPK_MAX = tksel_pkg::TOPK_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  tksel_pkg::item_t                 q_entry,
  output logic                             q_pop,
  input  logic [tksel_pkg::TOPK_W-1:0]     top_k,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tksel_pkg::class_id_t             out_class_id,
  output tksel_pkg::score_t                out_confidence,
  output logic [tksel_pkg::RANK_W-1:0]     out_rank,
  output logic                             out_last_result
);
  import tksel_pkg::*;

  localparam int FILL_W = $clog2(TOPK_MAX + 1);
  localparam int KW     = (FILL_W > TOPK_W) ? FILL_W : TOPK_W;

  state_t            state_r;
  state_t            state_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] left_r;
  logic [FILL_W-1:0] left_nxt;
  logic [FILL_W-1:0] rank_r;
  logic [FILL_W-1:0] rank_nxt;
  cell_t             cell_r     [TOPK_MAX];
  cell_t             cell_nxt   [TOPK_MAX];
  cell_t             ins_cell   [TOPK_MAX];
  cell_t             shift_cell [TOPK_MAX];
  cell_t             new_cell;
  logic [TOPK_MAX-1:0] gt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  class_id_t         out_class_id_r;
  class_id_t         out_class_id_nxt;
  score_t            out_confidence_r;
  score_t            out_confidence_nxt;
  logic [RANK_W-1:0] out_rank_r;
  logic [RANK_W-1:0] out_rank_nxt;
  logic              out_last_r;
  logic              out_last_nxt;

  logic              do_ins;
  logic [FILL_W-1:0] fill_ins;
  logic [FILL_W-1:0] fill_after;
  logic [KW-1:0]     k_ext;
  logic [KW-1:0]     fill_ext;
  logic [FILL_W-1:0] n_emit;

  assign out_valid       = out_valid_r;
  assign out_class_id    = out_class_id_r;
  assign out_confidence  = out_confidence_r;
  assign out_rank        = out_rank_r;
  assign out_last_result = out_last_r;

  assign new_cell.score = q_entry.score;
  assign new_cell.id    = q_entry.id;

  for (genvar i = 0; i < TOPK_MAX; i++) begin : g_cell
    assign gt[i] = (FILL_W'(i) < fill_r) && (cell_r[i].score > q_entry.score);
    if (i == 0) begin : g_first
      assign ins_cell[i] = gt[i] ? cell_r[i] : new_cell;
    end else begin : g_rest
      assign ins_cell[i] = gt[i]     ? cell_r[i] :
                           gt[i - 1] ? new_cell :
                                       cell_r[i - 1];
    end
    if (i == TOPK_MAX - 1) begin : g_tail
      assign shift_cell[i] = cell_r[i];
    end else begin : g_body
      assign shift_cell[i] = cell_r[i + 1];
    end
  end

  assign do_ins     = q_valid && q_entry.keep && !gt[TOPK_MAX - 1];
  assign fill_ins   = (fill_r == FILL_W'(TOPK_MAX)) ? fill_r : fill_r + FILL_W'(1);
  assign fill_after = do_ins ? fill_ins : fill_r;
  assign k_ext      = (KW'(top_k) > KW'(TOPK_MAX)) ? KW'(TOPK_MAX) : KW'(top_k);
  assign fill_ext   = KW'(fill_after);
  assign n_emit     = FILL_W'((k_ext < fill_ext) ? k_ext : fill_ext);

  always_comb begin
    state_nxt          = state_r;
    fill_nxt           = fill_r;
    left_nxt           = left_r;
    rank_nxt           = rank_r;
    cell_nxt           = cell_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_class_id_nxt   = out_class_id_r;
    out_confidence_nxt = out_confidence_r;
    out_rank_nxt       = out_rank_r;
    out_last_nxt       = out_last_r;
    q_pop              = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (do_ins) begin
            cell_nxt = ins_cell;
            fill_nxt = fill_ins;
          end
          if (q_entry.last) begin
            if (n_emit == '0) begin
              fill_nxt = '0;
            end else begin
              state_nxt = ST_EMIT;
              left_nxt  = n_emit;
              rank_nxt  = '0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_class_id_nxt   = cell_r[0].id;
          out_confidence_nxt = cell_r[0].score;
          out_rank_nxt       = RANK_W'(rank_r);
          out_last_nxt       = left_r == FILL_W'(1);
          cell_nxt           = shift_cell;
          rank_nxt           = rank_r + FILL_W'(1);
          left_nxt           = left_r - FILL_W'(1);
          if (left_r == FILL_W'(1)) begin
            state_nxt = ST_COLLECT;
            fill_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      fill_r      <= '0;
      left_r      <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r           <= cell_nxt;
    out_class_id_r   <= out_class_id_nxt;
    out_confidence_r <= out_confidence_nxt;
    out_rank_r       <= out_rank_nxt;
    out_last_r       <= out_last_nxt;
  end

endmodule

/* rtl/core/top_k_score_selector_top.sv */
// Streaming top-k score selector.
// Input channel (in_valid / in_stall): one signed Q16.16 class score per
// transfer, in class-index order; in_last_score marks the final score of a
// frame. Scores after MAX_CLASSES in a frame are dropped, but their last
// mark still closes the frame.
// Result channel (out_valid / out_stall): on frame close, min(top_k, scores
// kept) results, best first, one per transfer, with class_id, confidence,
// rank and out_last_result on the final one. Equal scores put the higher
// class index first.
// Configuration (cfg_valid / cfg_ready): writes top_k; cfg_ready is always
// high. Write only while the block is idle. Values above TOPK_MAX act as
// TOPK_MAX; zero closes frames with no results.
// Throughput: one score per cycle while collecting, set by the compare
// chain of TOPK_MAX cells that inserts a score per cycle. While a frame's
// results drain, the two-entry queue keeps taking scores, then in_stall
// rises. The first result is valid once the closing score has passed the
// queue, the switch to the emit state and the output register.
// Reset: list and class count empty, top_k = 5, no result pending.
// A stalled result holds; the list stops draining until it is taken.
module top_k_score_selector_top #(
  parameter int TOPK_MAX    = tksel_pkg::TOPK_MAX_DEF,
  parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tksel_pkg::score_t            in_score,
  input  logic                         in_last_score,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tksel_pkg::class_id_t         out_class_id,
  output tksel_pkg::score_t            out_confidence,
  output logic [tksel_pkg::RANK_W-1:0] out_rank,
  output logic                         out_last_result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tksel_pkg::TOPK_W-1:0] cfg_top_k
);
  import tksel_pkg::*;

  logic              cfg_wr;
  logic [TOPK_W-1:0] top_k_r;
  logic              q_full;
  logic              q_push;
  item_t             q_item;
  logic              q_pop;
  logic              q_valid;
  item_t             q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r <= TOPK_RESET;
    end else if (cfg_wr) begin
      top_k_r <= cfg_top_k;
    end
  end

  tksel_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_score      (in_score),
    .in_last_score (in_last_score),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  tksel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tksel_back #(
    .TOPK_MAX (TOPK_MAX)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_head),
    .q_pop           (q_pop),
    .top_k           (top_k_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_id    (out_class_id),
    .out_confidence  (out_confidence),
    .out_rank        (out_rank),
    .out_last_result (out_last_result)
  );

endmodule

/* rtl/core/tksel_checker.sv */
`include "assert_macros.svh"

module tksel_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last_score,
  input logic                         out_valid,
  input logic                         out_stall,
  input tksel_pkg::class_id_t         out_class_id,
  input tksel_pkg::score_t            out_confidence,
  input logic [tksel_pkg::RANK_W-1:0] out_rank,
  input logic                         out_last_result
);
  import tksel_pkg::*;

  localparam int PAYLOAD_W = CLASS_ID_W + SCORE_W + RANK_W + 1;

  logic [RANK_W-1:0]    exp_rank_r;
  logic [RANK_W-1:0]    exp_rank_nxt;
  logic [3:0]           pend_r;
  logic [3:0]           pend_nxt;
  logic                 in_close;
  logic                 out_close;
  logic                 out_xfer;
  logic [PAYLOAD_W-1:0] out_payload;

  assign out_xfer    = out_valid && !out_stall;
  assign in_close    = in_valid && !in_stall && in_last_score;
  assign out_close   = out_xfer && out_last_result;
  assign out_payload = {out_class_id, out_confidence, out_rank, out_last_result};

  always_comb begin
    exp_rank_nxt = exp_rank_r;
    if (out_xfer) begin
      exp_rank_nxt = out_last_result ? '0 : exp_rank_r + RANK_W'(1);
    end
    pend_nxt = pend_r;
    if (in_close && pend_r != 4'hF) begin
      pend_nxt = pend_nxt + 4'd1;
    end
    if (out_close && pend_nxt != 4'd0) begin
      pend_nxt = pend_nxt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rank_r <= '0;
      pend_r     <= '0;
    end else begin
      exp_rank_r <= exp_rank_nxt;
      pend_r     <= pend_nxt;
    end
  end

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload))
  `ASSERT_SAME(a_rank_seq, out_valid, out_rank == exp_rank_r)
  `ASSERT_SAME(a_frame_closed, out_valid, pend_r != 4'd0)

endmodule

bind top_k_score_selector_top tksel_checker u_tksel_checker (.*);

/* tb/testbench.sv */
module testbench;
  import tksel_pkg::*;

  localparam int TOPK_MAX       = TOPK_MAX_DEF;
  localparam int MAX_CLASSES    = MAX_CLASSES_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    class_id_t             pick_id;
    score_t                confidence;
    logic [RANK_W-1:0]     rank;
    logic                  last_result;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  score_t              in_score = '0;
  logic                in_last_score = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  class_id_t           out_class_id;
  score_t              out_confidence;
  logic [RANK_W-1:0]   out_rank;
  logic                out_last_result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TOPK_W-1:0]   cfg_top_k = '0;

  top_k_score_selector_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_score        (in_score),
    .in_last_score   (in_last_score),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_id    (out_class_id),
    .out_confidence  (out_confidence),
    .out_rank        (out_rank),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_top_k       (cfg_top_k)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted selector state
  score_t            board_score [TOPK_MAX];
  class_id_t         board_id [TOPK_MAX];
  int                board_fill = 0;
  int                seen_classes = 0;
  logic [TOPK_W-1:0] report_k = TOPK_RESET;
  pick_t             pending_picks [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int idle_run = 0;
  int faults = 0;
  int scores_sent = 0;
  int frames_closed = 0;
  int picks_checked = 0;
  int topk_writes = 0;

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  task automatic rank_score(input score_t s, input logic is_last);
    int    pos;
    int    top;
    int    k;
    int    n;
    pick_t p;
    if (seen_classes < MAX_CLASSES) begin
      pos = 0;
      while (pos < board_fill && board_score[pos] > s) pos++;
      if (pos < TOPK_MAX) begin
        top = (board_fill < TOPK_MAX) ? board_fill : TOPK_MAX - 1;
        for (int j = top; j > pos; j--) begin
          board_score[j] = board_score[j-1];
          board_id[j]    = board_id[j-1];
        end
        board_score[pos] = s;
        board_id[pos]    = class_id_t'(seen_classes);
        if (board_fill < TOPK_MAX) board_fill++;
      end
      seen_classes++;
    end
    if (is_last) begin
      k = (report_k > TOPK_MAX) ? TOPK_MAX : report_k;
      n = (k < board_fill) ? k : board_fill;
      for (int r = 0; r < n; r++) begin
        p.pick_id     = board_id[r];
        p.confidence  = board_score[r];
        p.rank        = r[RANK_W-1:0];
        p.last_result = (r == n - 1);
        pending_picks = {pending_picks, p};
      end
      board_fill   = 0;
      seen_classes = 0;
      frames_closed++;
    end
  endtask

  task automatic send_score(input score_t s, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_score      <= s;
    in_last_score <= is_last;
    do @(posedge clk); while (in_stall);
    rank_score(s, is_last);
    scores_sent++;
  endtask

  function automatic score_t pick_score();
    score_t corners [4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'shFFFFFFFF};
    case ($urandom_range(3))
      0: return corners[$urandom_range(3)];
      1: return score_t'($urandom_range(6)) - 3;
      default: return score_t'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_score(pick_score(), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_top_k(input logic [TOPK_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_top_k <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    report_k = v;
    topk_writes++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        note_fault($sformatf("unexpected result: id=%0d conf=%h rank=%0d last=%b",
                             out_class_id, out_confidence, out_rank, out_last_result));
      end else begin
        e = pending_picks.pop_front();
        picks_checked++;
        if (out_class_id !== e.pick_id || out_confidence !== e.confidence ||
            out_rank !== e.rank || out_last_result !== e.last_result) begin
          note_fault($sformatf(
            "exp id=%0d conf=%h rank=%0d last=%b, got id=%0d conf=%h rank=%0d last=%b",
            e.pick_id, e.confidence, e.rank, e.last_result,
            out_class_id, out_confidence, out_rank, out_last_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  task automatic test_directed();
    score_t a [5] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'shFFFFFFFF, 32'sh7FFFFFFF};
    set_idle(0, 0);
    for (int i = 0; i < 5; i++) send_score(a[i], i == 4);
    send_score(32'sh00010000, 1'b1);
    write_top_k(5'd0);
    send_score(32'sh12345678, 1'b1);
    write_top_k(5'd31);
    for (int i = 0; i < 17; i++) send_score(score_t'(i * 1000 - 8000), i == 16);
    write_top_k(5'd16);
    send_score(32'sh5, 1'b0);
    send_score(32'sh5, 1'b0);
    send_score(-32'sh5, 1'b0);
    write_top_k(5'd2);
    send_score(32'sh5, 1'b0);
    send_score(32'sh0, 1'b1);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    write_top_k(5'd16);
    hold_request = 150;
    for (int f = 0; f < 5; f++) send_frame(6);
    wait_drained();
  endtask

  task automatic test_random_frames(input int goal);
    logic [TOPK_W-1:0] ks [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
    int sent;
    int len;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1)) write_top_k(ks[$urandom_range(4)]);
        else write_top_k(TOPK_W'($urandom_range(1, 16)));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 12);
      send_frame(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    set_idle(25, 74);
    test_random_frames(50);
    set_idle(74, 25);
    test_random_frames(50);
    set_idle(0, 0);
    test_random_frames(50);
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_picks.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", pending_picks.size()));
    end
    $display("Sent %0d scores in %0d frames, checked %0d ranked results", scores_sent,
             frames_closed, picks_checked);
    $display("Covered %0d top_k writes, list overflow, ties and long result hold-off",
             topk_writes);
    if (faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
